### design/vtpd_pkg.sv
// package for the vertex transform and perspective divide core
// holds widths, register indexes, reset matrix and shared types; no dependencies
package vtpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NUM_PAIRS     = 8;
  localparam int PAIR_W        = 64;
  localparam int IDX_W         = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int HOM_W         = 64;
  // quotient magnitude is limited below 2^32, plus one guard bit
  localparam int QUO_W         = 33;

  localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_PAIR_LAST = 4'd7;

  localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
    64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [HOM_W-1:0] hx;
    logic signed [HOM_W-1:0] hy;
    logic signed [HOM_W-1:0] hz;
    logic signed [HOM_W-1:0] hw;
  } hom_t;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] oz;
    logic               w_zero;
    logic               ovf;
  } res_t;

endpackage

### design/vtpd_front.sv
// front end: accepts vertices and computes homogeneous x, y, z, w
// three pipeline stages (multiply, row sum, truncate); depends on vtpd_pkg
module vtpd_front #(
  parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [vtpd_pkg::PAIR_W-1:0]           pairs [vtpd_pkg::NUM_PAIRS],
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vtpd_pkg::COORD_W-1:0]   vx,
  input  logic signed [vtpd_pkg::COORD_W-1:0]   vy,
  input  logic signed [vtpd_pkg::COORD_W-1:0]   vz,
  output logic                                  hom_valid,
  input  logic                                  hom_ready,
  output vtpd_pkg::hom_t                        hom
);
  localparam int CW = vtpd_pkg::COORD_W;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;

  logic signed [CW-1:0] e [16];
  logic signed [PW-1:0] prod [12];
  logic signed [CW-1:0] tr [4];
  logic signed [CW-1:0] tr2 [4];
  logic signed [SW-1:0] sum [4];
  logic [2:0] vld;
  logic adv;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      e[2*k]   = pairs[k][CW-1:0];
      e[2*k+1] = pairs[k][PW-1:CW];
    end
  end

  assign adv       = !vld[2] || hom_ready;
  assign in_ready  = adv;
  assign hom_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // sum of floors of products plus floor of summed fractions is floor of exact sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        prod[r]     <= vx * e[r];
        prod[4 + r] <= vy * e[4 + r];
        prod[8 + r] <= vz * e[8 + r];
        tr[r]       <= e[12 + r];
      end
      for (int r = 0; r < 4; r++) begin
        sum[r] <= SW'(prod[r]) + SW'(prod[4 + r]) + SW'(prod[8 + r]);
        tr2[r] <= tr[r];
      end
      hom.hx <= vtpd_pkg::HOM_W'(sum[0] >>> FRAC_BITS) + vtpd_pkg::HOM_W'(tr2[0]);
      hom.hy <= vtpd_pkg::HOM_W'(sum[1] >>> FRAC_BITS) + vtpd_pkg::HOM_W'(tr2[1]);
      hom.hz <= vtpd_pkg::HOM_W'(sum[2] >>> FRAC_BITS) + vtpd_pkg::HOM_W'(tr2[2]);
      hom.hw <= vtpd_pkg::HOM_W'(sum[3] >>> FRAC_BITS) + vtpd_pkg::HOM_W'(tr2[3]);
    end
  end
  // translation terms ride through tr and tr2 alongside the products to meet their row sums
endmodule

### design/vtpd_fifo.sv
// short queue between front and back, two entries
// carries hom_t records; depends on vtpd_pkg
module vtpd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  vtpd_pkg::hom_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output vtpd_pkg::hom_t rd_data
);
  vtpd_pkg::hom_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end
endmodule

### design/vtpd_back.sv
// back end: pipelined restoring divider for x/w, y/w, z/w with saturation
// one quotient bit per stage per lane; depends on vtpd_pkg
module vtpd_back #(
  parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vtpd_pkg::hom_t hom,
  output logic           out_valid,
  input  logic           out_ready,
  output vtpd_pkg::res_t res
);
  localparam int HW = vtpd_pkg::HOM_W;
  localparam int QW = vtpd_pkg::QUO_W;
  localparam int CW = vtpd_pkg::COORD_W;
  // dividend magnitude shifted left by FRAC_BITS
  localparam int NW = HW + FRAC_BITS;
  localparam int NS = QW;

  logic [NS:0]       vld;
  logic [NW-1:0]     num [NS+1][3];
  logic [HW-1:0]     rem [NS+1][3];
  logic [QW-1:0]     quo [NS+1][3];
  logic [2:0]        neg [NS+1];
  logic              big [NS+1][3];
  logic [HW-1:0]     dm  [NS+1];
  logic              wz  [NS+1];
  logic              adv;

  assign adv       = !vld[NS] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NS];

  logic [HW-1:0] den_mag;
  logic [HW-1:0] nmag [3];
  logic signed [HW-1:0] nn [3];
  always_comb begin
    nn[0] = hom.hx; nn[1] = hom.hy; nn[2] = hom.hz;
    den_mag = hom.hw[HW-1] ? HW'(-hom.hw) : hom.hw;
    for (int l = 0; l < 3; l++) nmag[l] = nn[l][HW-1] ? HW'(-nn[l]) : nn[l];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-1:0], in_valid};
  end

  // stage 0 loads; quotient bits above QW are caught by a high-part compare
  always_ff @(posedge clk) begin
    if (adv) begin
      dm[0] <= den_mag;
      wz[0] <= hom.hw == '0;
      for (int l = 0; l < 3; l++) begin
        // low QW dividend bits move to the top, fed in one per stage
        num[0][l] <= {nmag[l], FRAC_BITS'(0)} << (NW - QW);
        rem[0][l] <= (nmag[l] >> (QW - FRAC_BITS));
        quo[0][l] <= '0;
        neg[0][l] <= nn[l][HW-1] ^ hom.hw[HW-1];
        big[0][l] <= (nmag[l] >> (QW - FRAC_BITS)) >= den_mag;
      end
      for (int s = 0; s < NS; s++) begin
        dm[s+1] <= dm[s];
        wz[s+1] <= wz[s];
        neg[s+1] <= neg[s];
        for (int l = 0; l < 3; l++) begin
          logic [HW:0] t;
          t = {rem[s][l], num[s][l][NW-1]};
          if (t >= {1'b0, dm[s]}) begin
            rem[s+1][l] <= HW'(t - {1'b0, dm[s]});
            quo[s+1][l] <= {quo[s][l][QW-2:0], 1'b1};
          end else begin
            rem[s+1][l] <= t[HW-1:0];
            quo[s+1][l] <= {quo[s][l][QW-2:0], 1'b0};
          end
          num[s+1][l] <= num[s][l] << 1;
          big[s+1][l] <= big[s][l];
        end
      end
    end
  end

  logic [CW-1:0] o [3];
  logic ov [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ov[l] = 1'b0;
      o[l]  = '0;
      if (big[NS][l] || (quo[NS][l] >> FRAC_BITS) >= QW'(1 << (CW - FRAC_BITS))) begin
        ov[l] = 1'b1;
        o[l]  = neg[NS][l] ? vtpd_pkg::NEG_LIMIT : vtpd_pkg::POS_LIMIT;
      end else if (neg[NS][l]) begin
        if (quo[NS][l] > QW'(vtpd_pkg::NEG_LIMIT)) begin
          ov[l] = 1'b1; o[l] = vtpd_pkg::NEG_LIMIT;
        end else o[l] = CW'(-quo[NS][l]);
      end else if (quo[NS][l] > QW'(vtpd_pkg::POS_LIMIT)) begin
        ov[l] = 1'b1; o[l] = vtpd_pkg::POS_LIMIT;
      end else o[l] = quo[NS][l][CW-1:0];
    end
    if (wz[NS]) begin
      res.ox = vtpd_pkg::POS_LIMIT; res.oy = vtpd_pkg::POS_LIMIT;
      res.oz = vtpd_pkg::POS_LIMIT; res.w_zero = 1'b1; res.ovf = 1'b0;
    end else begin
      res.ox = o[0]; res.oy = o[1]; res.oz = o[2];
      res.w_zero = 1'b0; res.ovf = ov[0] || ov[1] || ov[2];
    end
  end
endmodule

### design/vertex_transform_perspective_divide_core.sv
// top level of the vertex transform and perspective divide core
// holds the matrix registers and joins front, queue and back; depends on vtpd_pkg
//
// usage: vertices enter on the s_axis group (tdata = vert_x, vert_y, vert_z from bit 0),
// results leave on m_axis (tdata = out_x, out_y, out_z; tuser = w_is_zero, overflowed).
// the matrix is written through cfg_valid/cfg_ready/cfg_index/cfg_data, one 64-bit pair
// of elements per index 0..7; other indexes are ignored. write only while idle.
// throughput: one vertex per cycle while the receiver keeps accepting. from an accepted vertex
// to the earliest accept of its result lie three front stages (multiply, row sum, truncate), one
// in the queue, and a load stage plus 33 quotient-bit stages in the divider.
// reset loads the identity matrix and empties every stage.
// a stalled receiver freezes the divider pipeline; the queue lets the front run
// on until it fills, then s_axis_tready drops.
module vertex_transform_perspective_divide_core #(
  parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vtpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vtpd_pkg::PAIR_W-1:0]       cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [95:0]                       s_axis_tdata,  // vert_x, vert_y, vert_z
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [95:0]                       m_axis_tdata,  // out_x, out_y, out_z
  output logic [1:0]                        m_axis_tuser   // w_is_zero, overflowed
);
  logic [vtpd_pkg::PAIR_W-1:0] pairs [vtpd_pkg::NUM_PAIRS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs <= vtpd_pkg::PAIR_RESET;
    end else if (cfg_valid && cfg_index <= vtpd_pkg::REG_PAIR_LAST) begin
      pairs[cfg_index[vtpd_pkg::IDX_W-1:0]] <= cfg_data;
    end
  end

  logic h_valid, h_ready, q_valid, q_ready;
  vtpd_pkg::hom_t h, q;
  vtpd_pkg::res_t r;

  vtpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .pairs,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .vx(s_axis_tdata[31:0]), .vy(s_axis_tdata[63:32]), .vz(s_axis_tdata[95:64]),
    .hom_valid(h_valid), .hom_ready(h_ready), .hom(h)
  );

  vtpd_fifo u_fifo (
    .clk, .rst, .wr_valid(h_valid), .wr_ready(h_ready), .wr_data(h),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q)
  );

  vtpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .hom(q),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(r)
  );

  assign m_axis_tdata = {r.oz, r.oy, r.ox};
  assign m_axis_tuser = {r.ovf, r.w_zero};
endmodule

### tb/tb_top.sv
// self-checking bench for vertex_transform_perspective_divide_core
// predicts each homogenized vertex from its own matrix copy; depends on vtpd_pkg and the core
module tb_top;

  localparam int FRAC = vtpd_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // first result of the back-to-back phase starts the long hold-off
  localparam int HOLD_AT = 218;
  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vtpd_pkg::PAIR_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  vertex_transform_perspective_divide_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  logic [vtpd_pkg::PAIR_W-1:0] matrix_copy [vtpd_pkg::NUM_PAIRS];
  logic [95:0] vertex_q [$];
  vtpd_pkg::res_t vertex_result_q [$];
  int mismatch_cnt = 0;
  int result_cnt = 0;
  int cycle_cnt = 0;
  bit no_idle = 1'b0;

  function automatic logic [63:0] elem_ext(int i);
    logic [31:0] e;
    e = matrix_copy[i >> 1][(i & 1) * 32 +: 32];
    return {{32{e[31]}}, e};
  endfunction

  // floor of the full-width dot product, kept modulo 2^64
  function automatic logic [63:0] hom_row(logic [63:0] v [3], int r);
    logic [63:0] hi, lo, p;
    logic signed [63:0] a, b;
    hi = elem_ext(12 + r);
    lo = '0;
    for (int c = 0; c < 3; c++) begin
      a = v[c];
      b = elem_ext(4 * c + r);
      p = a * b;
      hi = hi + 64'($signed(p) >>> FRAC);
      lo = lo + (p & ((64'd1 << FRAC) - 1));
    end
    return hi + (lo >> FRAC);
  endfunction

  // returns {saturated, quotient}
  function automatic logic [32:0] fix_quotient(logic [63:0] num, logic [63:0] den);
    logic nneg, dneg, neg;
    logic [63:0] nm, dm, ip, rem, frac, mag;
    nneg = num[63];
    dneg = den[63];
    neg = nneg ^ dneg;
    nm = nneg ? -num : num;
    dm = dneg ? -den : den;
    ip = nm / dm;
    rem = nm % dm;
    frac = '0;
    if (ip >= (64'd1 << (32 - FRAC)))
      return {1'b1, neg ? vtpd_pkg::NEG_LIMIT : vtpd_pkg::POS_LIMIT};
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= dm) begin
        rem = rem - dm;
        frac[0] = 1'b1;
      end
    end
    mag = (ip << FRAC) | frac;
    if (neg) begin
      if (mag > {32'd0, vtpd_pkg::NEG_LIMIT}) return {1'b1, vtpd_pkg::NEG_LIMIT};
      return {1'b0, 32'(-mag)};
    end
    if (mag > {32'd0, vtpd_pkg::POS_LIMIT}) return {1'b1, vtpd_pkg::POS_LIMIT};
    return {1'b0, mag[31:0]};
  endfunction

  function automatic vtpd_pkg::res_t project_vertex(logic [95:0] vin);
    logic [63:0] v [3];
    logic [63:0] h [4];
    logic [32:0] q [3];
    vtpd_pkg::res_t res;
    for (int c = 0; c < 3; c++) v[c] = {{32{vin[c*32+31]}}, vin[c*32 +: 32]};
    for (int r = 0; r < 4; r++) h[r] = hom_row(v, r);
    if (h[3] == 0) begin
      res = '{ox: vtpd_pkg::POS_LIMIT, oy: vtpd_pkg::POS_LIMIT, oz: vtpd_pkg::POS_LIMIT,
              w_zero: 1'b1, ovf: 1'b0};
    end else begin
      for (int r = 0; r < 3; r++) q[r] = fix_quotient(h[r], h[3]);
      res = '{ox: q[0][31:0], oy: q[1][31:0], oz: q[2][31:0], w_zero: 1'b0,
              ovf: q[0][32] | q[1][32] | q[2][32]};
    end
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_fix(int min_shift);
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0: return vtpd_pkg::POS_LIMIT;
      1: return vtpd_pkg::NEG_LIMIT;
      2: return 32'd0;
      3: return 32'h0001_0000;
      default: return 32'($signed($urandom) >>> $urandom_range(min_shift, 30));
    endcase
  endfunction

  // vertex driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        vertex_result_q.push_back(project_vertex(vertex_q[0]));
        vertex_q.pop_front();
        if (!no_idle) tx_gap = gap_len();
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (vertex_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= vertex_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted on its own
  int hold_cnt = 0;
  int out_seen = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      out_seen <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_seen <= out_seen + 1;
      if (out_seen == HOLD_AT && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD_LEN;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // result monitor with random backpressure
  int rx_gap = 0;
  always @(posedge clk) begin
    vtpd_pkg::res_t exp_res;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (vertex_result_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h %b", $time, m_axis_tdata, m_axis_tuser);
          mismatch_cnt++;
        end else begin
          exp_res = vertex_result_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.ox) begin
            $display("%0t: out_x expected %h actual %h", $time, exp_res.ox, m_axis_tdata[31:0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[63:32] !== exp_res.oy) begin
            $display("%0t: out_y expected %h actual %h", $time, exp_res.oy, m_axis_tdata[63:32]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[95:64] !== exp_res.oz) begin
            $display("%0t: out_z expected %h actual %h", $time, exp_res.oz, m_axis_tdata[95:64]);
            mismatch_cnt++;
          end
          if (m_axis_tuser[0] !== exp_res.w_zero) begin
            $display("%0t: w_is_zero expected %b actual %b", $time, exp_res.w_zero,
                     m_axis_tuser[0]);
            mismatch_cnt++;
          end
          if (m_axis_tuser[1] !== exp_res.ovf) begin
            $display("%0t: overflowed expected %b actual %b", $time, exp_res.ovf,
                     m_axis_tuser[1]);
            mismatch_cnt++;
          end
        end
        if (!no_idle) rx_gap = gap_len();
      end
      if (hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_pair(logic [vtpd_pkg::CFG_IDX_W-1:0] idx,
                            logic [vtpd_pkg::PAIR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= vtpd_pkg::REG_PAIR_LAST) matrix_copy[idx] = val;
  endtask

  task automatic load_matrix(logic [31:0] e [16]);
    for (int k = 0; k < vtpd_pkg::NUM_PAIRS; k++)
      write_pair(k[vtpd_pkg::CFG_IDX_W-1:0], {e[2*k+1], e[2*k]});
  endtask

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_q.push_back({z, y, x});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (vertex_q.size() != 0 || s_axis_tvalid || vertex_result_q.size() != 0)
      @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  initial begin
    logic [31:0] e [16];
    int mode;
    for (int k = 0; k < vtpd_pkg::NUM_PAIRS; k++) matrix_copy[k] = vtpd_pkg::PAIR_RESET[k];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity matrix from reset
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT);
    push_vertex(vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT);
    push_vertex(vtpd_pkg::POS_LIMIT, vtpd_pkg::NEG_LIMIT, 32'hffff_ffff);
    push_vertex(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
    push_vertex(32'h1234_5678, 32'h8765_4321, 32'hdead_beef);
    wait_drained();

    // all zeros: w is zero for every vertex
    for (int i = 0; i < 16; i++) e[i] = '0;
    load_matrix(e);
    push_vertex(32'h0001_0000, 32'h0, vtpd_pkg::NEG_LIMIT);
    push_vertex(vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT);
    wait_drained();

    // extreme elements and a tiny w, forcing saturation both ways
    for (int i = 0; i < 16; i++) e[i] = vtpd_pkg::POS_LIMIT;
    load_matrix(e);
    push_vertex(vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT);
    push_vertex(vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT);
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h1, 32'hffff_ffff, 32'h0);
    wait_drained();
    for (int i = 0; i < 16; i++) e[i] = vtpd_pkg::NEG_LIMIT;
    e[15] = 32'h0000_0001;
    load_matrix(e);
    push_vertex(vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT, vtpd_pkg::POS_LIMIT);
    push_vertex(vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT, vtpd_pkg::NEG_LIMIT);
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h0001_0000, 32'h0, 32'h0);
    wait_drained();

    // writes past the last pair must leave the matrix alone
    write_pair(4'd8, {64{1'b1}});
    write_pair(4'd15, 64'h5555_aaaa_5555_aaaa);
    push_vertex(32'h0002_0000, 32'h0003_0000, 32'hfffe_0000);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      mode = ph % 3;
      no_idle = (ph == 4);
      for (int i = 0; i < 16; i++) e[i] = rand_fix(8);
      if (mode == 1) begin
        // perspective style: w = -z, so z = 0 gives zero w
        e[3] = '0;
        e[7] = '0;
        e[11] = 32'hffff_0000;
        e[15] = '0;
      end
      if (ph == 0) write_pair(4'd9, 64'(~0));
      load_matrix(e);
      for (int n = 0; n < 50; n++) begin
        if (mode == 1 && $urandom_range(0, 4) == 0)
          push_vertex(rand_fix(10), rand_fix(10), 32'h0);
        else if (mode == 2)
          push_vertex($urandom, $urandom, $urandom);
        else
          push_vertex(rand_fix(10), rand_fix(10), rand_fix(10));
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && vertex_result_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
